>>> sv/pcsf_pkg.sv
// Shared types, codes, constants and helpers of the palette sweep crossfade engine.
package pcsf_pkg;

    // Default sizes of the strip and of the palette.
    localparam int DEF_LED_COUNT     = 1024;
    localparam int DEF_PALETTE_DEPTH = 64;

    // Widths of the shared divider, of colours, of entry counts and of the configuration registers and their indexes.
    localparam int DIV_W    = 16;
    localparam int COLOUR_W = 24;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 3;

    // Command codes.
    localparam logic [2:0] FN_STAGE  = 3'd0;
    localparam logic [2:0] FN_COMMIT = 3'd1;
    localparam logic [2:0] FN_SINGLE = 3'd2;
    localparam logic [2:0] FN_QUERY  = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILL_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [7:0]       RST_FILL_STEP  = 8'd16;
    localparam logic [7:0]       RST_FADE_WIDTH = 8'd12;
    localparam logic [7:0]       RST_THRESHOLD  = 8'd5;
    localparam logic [CFG_W-1:0] RST_RED_GAIN   = 11'd1024;
    localparam logic [CFG_W-1:0] RST_GREEN_GAIN = 11'd768;
    localparam logic [CFG_W-1:0] RST_BLUE_GAIN  = 11'd922;

    // One command beat.
    typedef struct packed {
        logic [2:0]  func;
        logic [5:0]  entry_index;
        logic [6:0]  entry_count;
        logic [9:0]  led_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       wipe_active;
        logic       applied;
    } out_t;

    // Scales a raw byte by a Q10 gain, truncating and saturating at full scale.
    function automatic logic [7:0] gain_ch(input logic [7:0] raw, input logic [CFG_W-1:0] gain);
        logic [18:0] prod;
        prod = 19'(raw) * 19'(gain);
        gain_ch = (prod[18:10] > 9'd255) ? 8'hFF : prod[17:10];
    endfunction

endpackage

>>> sv/pcsf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pcsf_ram #(
    parameter int W = 24,
    parameter int D = 64,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/pcsf_div.sv
// Unsigned restoring divider producing one quotient bit per cycle.
module pcsf_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [pcsf_pkg::DIV_W-1:0] num,
    input  logic [pcsf_pkg::DIV_W-1:0] den,
    output logic                    run,
    output logic                    done,
    output logic [pcsf_pkg::DIV_W-1:0] quot
);
    import pcsf_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   trial;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quot_reg[DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CW'(DIV_W);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next  = trial[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[DIV_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign run  = run_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> sv/palette_sweep_crossfade.sv
// Top level of the palette sweep crossfade colour engine.
//
//  Channel   | Handshake            | Payload
//  ----------+----------------------+-------------------------------
//  command   | start / busy         | cmd (in_t)
//  result    | done (one cycle)     | result (out_t)
//  config    | cfg_we               | cfg_idx, cfg_wdata
//
// Stage, tick and unused commands answer in the cycle after they are taken and leave busy low.
// A commit walks the palette: it compares staged and target entries when the size is unchanged and ends there if
// none differs, else it copies max(n, size) entries and runs the block-length division.
// A pixel query runs two divisions, and three more in the blend zone,
// on the bit-serial divider that all divisions share.
// Reset clears all control state; the palette memories are not cleared.
// The result beat cannot be stalled and is shown for exactly one cycle.
module palette_sweep_crossfade #(
    parameter int LED_COUNT     = pcsf_pkg::DEF_LED_COUNT,
    parameter int PALETTE_DEPTH = pcsf_pkg::DEF_PALETTE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  pcsf_pkg::in_t                       cmd,
    output logic                                done,
    output pcsf_pkg::out_t                      result,
    input  logic                                cfg_we,
    input  logic [pcsf_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [pcsf_pkg::CFG_W-1:0]          cfg_wdata
);
    import pcsf_pkg::*;

    // The head and the blend edge must also hold any 10-bit LED index plus a blend zone.
    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int HW = $clog2(((LED_COUNT > 1024) ? LED_COUNT : 1024) + 256);
    localparam logic [HW:0]      LED_END = (HW+1)'(LED_COUNT);
    localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(PALETTE_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CMP  = 4'd1;
    localparam logic [3:0] S_CPY  = 4'd2;
    localparam logic [3:0] S_PER  = 4'd3;
    localparam logic [3:0] S_PERW = 4'd4;
    localparam logic [3:0] S_QD1  = 4'd5;
    localparam logic [3:0] S_QW1  = 4'd6;
    localparam logic [3:0] S_QD2  = 4'd7;
    localparam logic [3:0] S_QW2  = 4'd8;
    localparam logic [3:0] S_QRD  = 4'd9;
    localparam logic [3:0] S_BMUL = 4'd10;
    localparam logic [3:0] S_BDIV = 4'd11;
    localparam logic [3:0] S_BDW  = 4'd12;

    // Configuration registers.
    logic [7:0]       fill_reg, fade_reg, thr_reg;
    logic [CFG_W-1:0] rgain_reg, ggain_reg, bgain_reg;

    // Architectural state.
    logic [COUNT_W-1:0]  tsize_reg, tsize_next, psize_reg, psize_next;
    logic                tpal_reg, tpal_next, ppal_reg, ppal_next;
    logic [COLOUR_W-1:0] single_reg, single_next;
    logic [HW-1:0]       head_reg, head_next;
    logic                wiping_reg, wiping_next;
    logic [DIV_W-1:0]    tper_reg, tper_next, pper_reg, pper_next;

    // Sequencer and work registers.
    logic [3:0]          state_reg, state_next;
    logic                commit_reg, commit_next;
    logic [COUNT_W-1:0]  n_reg, n_next, lim_reg, lim_next, cnt_reg, cnt_next;
    logic [COUNT_W-1:0]  pidx_reg, pidx_next;
    logic                pend_reg, pend_next, chg_reg, chg_next;
    logic [9:0]          led_reg, led_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic [COLOUR_W-1:0] newc_reg, newc_next, oldc_reg, oldc_next;
    logic [COLOUR_W-1:0] outc_reg, outc_next;
    logic [1:0]          ch_reg, ch_next;
    logic [15:0]         prod_reg, prod_next;
    logic                neg_reg, neg_next;
    out_t                res_reg, res_next;
    logic                done_reg, done_next;

    // Memory ports.
    logic                stg_we, tgt_we, prv_we;
    logic [AW-1:0]       stg_waddr, tgt_waddr, prv_waddr;
    logic [AW-1:0]       stg_raddr, tgt_raddr, prv_raddr;
    logic [COLOUR_W-1:0] stg_wdata, tgt_wdata, prv_wdata;
    logic [COLOUR_W-1:0] stg_rdata, tgt_rdata, prv_rdata;

    // Divider ports.
    logic             div_start, div_run, div_done;
    logic [DIV_W-1:0] div_num, div_den, div_quot;

    // Helpers.
    logic                accept;
    logic [COLOUR_W-1:0] gained;
    logic                cmp_hit;
    logic [COUNT_W-1:0]  idx_new, idx_old;
    logic [COLOUR_W-1:0] oldc_now;
    logic [HW:0]         led_ext, fade_edge, head_sum;
    logic [7:0]          ch_old, ch_new, ch_diff, blend_dist;
    logic [8:0]          blend_v;

    pcsf_ram #(.W(COLOUR_W), .D(PALETTE_DEPTH), .AW(AW)) u_staged (
        .clk(clk), .we(stg_we), .waddr(stg_waddr), .wdata(stg_wdata),
        .raddr(stg_raddr), .rdata(stg_rdata)
    );

    pcsf_ram #(.W(COLOUR_W), .D(PALETTE_DEPTH), .AW(AW)) u_target (
        .clk(clk), .we(tgt_we), .waddr(tgt_waddr), .wdata(tgt_wdata),
        .raddr(tgt_raddr), .rdata(tgt_rdata)
    );

    pcsf_ram #(.W(COLOUR_W), .D(PALETTE_DEPTH), .AW(AW)) u_previous (
        .clk(clk), .we(prv_we), .waddr(prv_waddr), .wdata(prv_wdata),
        .raddr(prv_raddr), .rdata(prv_rdata)
    );

    pcsf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .run(div_run), .done(div_done), .quot(div_quot)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // Gain scaling of the incoming raw colour.
    assign gained = {gain_ch(cmd.red_in, rgain_reg), gain_ch(cmd.green_in, ggain_reg),
                     gain_ch(cmd.blue_in, bgain_reg)};

    // Per-channel threshold comparison of staged and target entries.
    always_comb
    begin
        logic [7:0] a, b, d;
        cmp_hit = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            a = stg_rdata[8*c +: 8];
            b = tgt_rdata[8*c +: 8];
            d = (a > b) ? a - b : b - a;
            if (d > thr_reg)
            begin
                cmp_hit = 1'b1;
            end
        end
    end

    // Palette index clamped to the last entry.
    assign idx_new = (div_quot >= DIV_W'(tsize_reg)) ? tsize_reg - 1'b1 : div_quot[COUNT_W-1:0];
    assign idx_old = (div_quot >= DIV_W'(psize_reg)) ? psize_reg - 1'b1 : div_quot[COUNT_W-1:0];
    assign oldc_now = (ppal_reg && psize_reg != '0) ? prv_rdata : '0;

    // Blend zone geometry.
    assign led_ext    = (HW+1)'(led_reg);
    assign fade_edge  = led_ext + (HW+1)'(fade_reg);
    assign head_sum   = {1'b0, head_reg} + (HW+1)'(fill_reg);
    assign blend_dist = 8'({1'b0, head_reg} - led_ext);
    assign ch_old     = oldc_reg[8*ch_reg +: 8];
    assign ch_new     = newc_reg[8*ch_reg +: 8];
    assign ch_diff    = (ch_new >= ch_old) ? ch_new - ch_old : ch_old - ch_new;
    assign blend_v    = neg_reg ? 9'(ch_old) - 9'(div_quot[7:0])
                                : 9'(ch_old) + 9'(div_quot[7:0]);

    // Sequencer.
    always_comb
    begin
        tsize_next  = tsize_reg;
        psize_next  = psize_reg;
        tpal_next   = tpal_reg;
        ppal_next   = ppal_reg;
        single_next = single_reg;
        head_next   = head_reg;
        wiping_next = wiping_reg;
        tper_next   = tper_reg;
        pper_next   = pper_reg;
        state_next  = state_reg;
        commit_next = commit_reg;
        n_next      = n_reg;
        lim_next    = lim_reg;
        cnt_next    = cnt_reg;
        pidx_next   = pidx_reg;
        pend_next   = 1'b0;
        chg_next    = chg_reg;
        led_next    = led_reg;
        colour_next = colour_reg;
        newc_next   = newc_reg;
        oldc_next   = oldc_reg;
        outc_next   = outc_reg;
        ch_next     = ch_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        stg_we      = 1'b0;
        stg_waddr   = cmd.entry_index[AW-1:0];
        stg_wdata   = gained;
        stg_raddr   = cnt_reg[AW-1:0];
        tgt_we      = 1'b0;
        tgt_waddr   = pidx_reg[AW-1:0];
        tgt_wdata   = stg_rdata;
        tgt_raddr   = cnt_reg[AW-1:0];
        prv_we      = 1'b0;
        prv_waddr   = pidx_reg[AW-1:0];
        prv_wdata   = tgt_rdata;
        prv_raddr   = idx_old[AW-1:0];
        div_start   = 1'b0;
        div_num     = DIV_W'(led_reg);
        div_den     = tper_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next  = '0;
                    done_next = 1'b1;
                    led_next  = cmd.led_index;
                    colour_next = gained;
                    cnt_next  = '0;
                    chg_next  = 1'b0;
                    case (cmd.func)
                        FN_STAGE:
                        begin
                            stg_we = (6'(cmd.entry_index) < 6'(PALETTE_DEPTH))
                                     || (PALETTE_DEPTH == 64);
                            res_next.wipe_active = wiping_reg;
                        end
                        FN_COMMIT:
                        begin
                            res_next.wipe_active = wiping_reg;
                            if (cmd.entry_count != '0 && cmd.entry_count <= DEPTH_N)
                            begin
                                done_next   = 1'b0;
                                commit_next = 1'b1;
                                n_next      = cmd.entry_count;
                                if (cmd.entry_count != tsize_reg || !tpal_reg)
                                begin
                                    lim_next   = (cmd.entry_count > tsize_reg)
                                                 ? cmd.entry_count : tsize_reg;
                                    state_next = S_CPY;
                                end
                                else
                                begin
                                    lim_next   = cmd.entry_count;
                                    state_next = S_CMP;
                                end
                            end
                        end
                        FN_SINGLE:
                        begin
                            done_next   = 1'b0;
                            commit_next = 1'b0;
                            n_next      = '0;
                            lim_next    = tsize_reg;
                            state_next  = S_CPY;
                        end
                        FN_QUERY:
                        begin
                            done_next  = 1'b0;
                            state_next = S_QD1;
                        end
                        FN_TICK:
                        begin
                            if (wiping_reg)
                            begin
                                if (head_sum >= LED_END + (HW+1)'(fade_reg))
                                begin
                                    head_next   = HW'(LED_END + (HW+1)'(fade_reg));
                                    wiping_next = 1'b0;
                                end
                                else
                                begin
                                    head_next = head_sum[HW-1:0];
                                end
                            end
                            res_next.wipe_active = wiping_next;
                        end
                        default:
                        begin
                            res_next.wipe_active = wiping_reg;
                        end
                    endcase
                end
            end
            // Compare staged against target, one entry a cycle.
            S_CMP:
            begin
                if (cnt_reg < lim_reg)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pidx_next = cnt_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg && cmp_hit)
                begin
                    chg_next = 1'b1;
                end
                if (cnt_reg == lim_reg && !pend_reg)
                begin
                    cnt_next = '0;
                    if (chg_reg)
                    begin
                        state_next = S_CPY;
                    end
                    else
                    begin
                        res_next   = '0;
                        res_next.wipe_active = wiping_reg;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            // Save target into previous and, on a commit, load staged into target.
            S_CPY:
            begin
                if (cnt_reg < lim_reg)
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    pidx_next = cnt_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    prv_we = 1'b1;
                    tgt_we = commit_reg && (pidx_reg < n_reg);
                end
                if (cnt_reg == lim_reg && !pend_reg)
                begin
                    psize_next  = tsize_reg;
                    ppal_next   = tpal_reg;
                    pper_next   = tper_reg;
                    head_next   = '0;
                    wiping_next = 1'b1;
                    if (commit_reg)
                    begin
                        tsize_next = n_reg;
                        tpal_next  = 1'b1;
                        state_next = S_PER;
                    end
                    else
                    begin
                        single_next = colour_reg;
                        tpal_next   = 1'b0;
                        res_next    = '0;
                        res_next.wipe_active = 1'b1;
                        res_next.applied     = 1'b1;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            // Block length of the new palette.
            S_PER:
            begin
                div_start  = 1'b1;
                div_num    = DIV_W'(LED_COUNT);
                div_den    = DIV_W'(tsize_reg);
                state_next = S_PERW;
            end
            S_PERW:
            begin
                if (div_done)
                begin
                    tper_next  = (div_quot == '0) ? DIV_W'(1) : div_quot;
                    res_next   = '0;
                    res_next.wipe_active = wiping_reg;
                    res_next.applied     = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // Index into the target palette.
            S_QD1:
            begin
                div_start  = 1'b1;
                state_next = S_QW1;
            end
            S_QW1:
            begin
                tgt_raddr = idx_new[AW-1:0];
                if (div_done)
                begin
                    state_next = S_QD2;
                end
            end
            // Index into the previous palette.
            S_QD2:
            begin
                newc_next  = (tpal_reg && tsize_reg != '0) ? tgt_rdata : single_reg;
                div_start  = 1'b1;
                div_den    = pper_reg;
                state_next = S_QW2;
            end
            S_QW2:
            begin
                if (div_done)
                begin
                    state_next = S_QRD;
                end
            end
            // Choose the region of the wipe.
            S_QRD:
            begin
                oldc_next = oldc_now;
                ch_next   = '0;
                res_next  = '0;
                res_next.wipe_active = wiping_reg;
                if (!wiping_reg || fade_edge < {1'b0, head_reg})
                begin
                    {res_next.red_out, res_next.green_out, res_next.blue_out} = newc_reg;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (led_ext >= {1'b0, head_reg})
                begin
                    {res_next.red_out, res_next.green_out, res_next.blue_out} = oldc_now;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_BMUL;
                end
            end
            // Blend one channel.
            S_BMUL:
            begin
                prod_next  = 16'(ch_diff) * 16'(blend_dist);
                neg_next   = (ch_new < ch_old);
                state_next = S_BDIV;
            end
            S_BDIV:
            begin
                div_start  = 1'b1;
                div_num    = prod_reg;
                div_den    = DIV_W'(fade_reg);
                state_next = S_BDW;
            end
            S_BDW:
            begin
                if (div_done)
                begin
                    outc_next[8*ch_reg +: 8] = blend_v[7:0];
                    if (ch_reg == 2'd2)
                    begin
                        res_next = '0;
                        res_next.wipe_active = wiping_reg;
                        {res_next.red_out, res_next.green_out, res_next.blue_out} =
                            {blend_v[7:0], outc_reg[15:0]};
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_BMUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= RST_FILL_STEP;
            fade_reg  <= RST_FADE_WIDTH;
            thr_reg   <= RST_THRESHOLD;
            rgain_reg <= RST_RED_GAIN;
            ggain_reg <= RST_GREEN_GAIN;
            bgain_reg <= RST_BLUE_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_FILL_STEP:  fill_reg  <= cfg_wdata[7:0];
                REG_FADE_WIDTH: fade_reg  <= cfg_wdata[7:0];
                REG_THRESHOLD:  thr_reg   <= cfg_wdata[7:0];
                REG_RED_GAIN:   rgain_reg <= cfg_wdata;
                REG_GREEN_GAIN: ggain_reg <= cfg_wdata;
                REG_BLUE_GAIN:  bgain_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsize_reg  <= '0;
            psize_reg  <= '0;
            tpal_reg   <= 1'b0;
            ppal_reg   <= 1'b0;
            single_reg <= '0;
            head_reg   <= '0;
            wiping_reg <= 1'b0;
            tper_reg   <= DIV_W'(1);
            pper_reg   <= DIV_W'(1);
            state_reg  <= S_IDLE;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            tsize_reg  <= tsize_next;
            psize_reg  <= psize_next;
            tpal_reg   <= tpal_next;
            ppal_reg   <= ppal_next;
            single_reg <= single_next;
            head_reg   <= head_next;
            wiping_reg <= wiping_next;
            tper_reg   <= tper_next;
            pper_reg   <= pper_next;
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
        end
    end

    // Work registers.
    always_ff @(posedge clk)
    begin
        commit_reg <= commit_next;
        n_reg      <= n_next;
        lim_reg    <= lim_next;
        cnt_reg    <= cnt_next;
        pidx_reg   <= pidx_next;
        chg_reg    <= chg_next;
        led_reg    <= led_next;
        colour_reg <= colour_next;
        newc_reg   <= newc_next;
        oldc_reg   <= oldc_next;
        outc_reg   <= outc_next;
        ch_reg     <= ch_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
    end

    // A palette is only ever as large as the store.
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        tsize_reg <= DEPTH_N && psize_reg <= DEPTH_N)
        else $error("palette size beyond store depth");

    // Every change of the target restarts the wipe.
    a_applied: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.applied |-> result.wipe_active)
        else $error("applied beat without running wipe");

    // The shared divider is never restarted while it works.
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_run)
        else $error("divider restarted while running");

    // The head never passes the end of the strip plus the widest blend zone.
    a_head: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, head_reg} <= LED_END + (HW+1)'(255))
        else $error("wipe head out of range");

    // Memory writes happen only while copying or staging.
    a_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (tgt_we || prv_we) |-> state_reg == S_CPY && $past(state_reg) == S_CPY)
        else $error("palette write outside copy pass");

endmodule
